// ===== design/crcfc_pkg.sv =====
// Shared types, status codes and the CRC-16/MODBUS byte update for the frame checker.
// No dependencies; imported by every module of the checker.
package crcfc_pkg;

    // Frame status codes carried on the status item
    localparam logic [2:0] STAT_DATA        = 3'd0;
    localparam logic [2:0] STAT_COMMAND     = 3'd1;
    localparam logic [2:0] STAT_LEN_ERR     = 3'd2;
    localparam logic [2:0] STAT_BAD_MARKER  = 3'd3;
    localparam logic [2:0] STAT_BAD_VERSION = 3'd4;
    localparam logic [2:0] STAT_BAD_TYPE    = 3'd5;
    localparam logic [2:0] STAT_CRC_ERR     = 3'd6;

    // Item kinds on the output stream
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_MARKER  = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;
    localparam logic [1:0] REG_CMD     = 2'd2;
    localparam logic [1:0] REG_DATA    = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration snapshot
    typedef struct packed {
        logic [7:0] marker_byte;
        logic [7:0] version_code;
        logic [7:0] command_type_code;
        logic [7:0] data_type_code;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_index;
        logic [2:0]  frame_status;
        logic [15:0] declared_length;
        logic        frame_done;
    } t_result;

    // Results produced by one accepted input item
    typedef struct packed {
        logic    pay_valid;
        logic    stat_valid;
        t_result pay;
        t_result stat;
    } t_push;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/crcfc_parser.sv =====
// Frame parser: header capture, two-byte hold-back, running CRC and status decision.
// Depends on crcfc_pkg.
module crcfc_parser
    import crcfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    output t_push      o_push
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LW = (PW > 16) ? PW : 16;
    localparam logic [PW-1:0] MaxPos = PW'(MAX_FRAME_BYTES);

    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_held0, n_held0;
    logic [7:0]    r_held1, n_held1;
    logic [7:0]    r_marker, n_marker;
    logic [7:0]    r_version, n_version;
    logic [7:0]    r_type, n_type;
    logic [15:0]   r_length, n_length;
    logic          r_overlong, n_overlong;

    logic          release_en;
    logic          pay_ok;
    logic          short_frame;
    logic          crc_bad;
    logic [LW-1:0] idx_full;
    logic [2:0]    status;
    logic [15:0]   stat_len;

    // Header capture, CRC over the released byte, payload decision
    always_comb begin
        n_overlong = r_overlong | (r_pos >= MaxPos);
        n_marker   = r_marker;
        n_version  = r_version;
        n_type     = r_type;
        n_length   = r_length;
        case (r_pos)
            PW'(0):  n_marker = i_rx_byte;
            PW'(1):  n_version = i_rx_byte;
            PW'(2):  n_type = i_rx_byte;
            PW'(4):  n_length = {r_length[15:8], i_rx_byte};
            PW'(5):  n_length = {i_rx_byte, r_length[7:0]};
            default: ;
        endcase

        release_en = (r_pos >= PW'(2));
        n_crc      = release_en ? crc_feed(r_crc, r_held0) : r_crc;
        idx_full   = LW'(r_pos) - LW'(8);
        pay_ok     = release_en && !n_overlong && (r_pos >= PW'(8)) &&
                     (idx_full < LW'(n_length));

        n_held0 = r_held1;
        n_held1 = i_rx_byte;

        // Status priority: length, CRC, marker, version, type
        short_frame = (r_pos <= PW'(5));
        crc_bad     = (n_crc[7:0] != r_held1) || (n_crc[15:8] != i_rx_byte);
        stat_len    = n_length;
        if (short_frame || n_overlong) begin
            status   = STAT_LEN_ERR;
            stat_len = 16'd0;
        end else if (crc_bad) begin
            status   = STAT_CRC_ERR;
            stat_len = 16'd0;
        end else if (n_marker != i_cfg.marker_byte) begin
            status = STAT_BAD_MARKER;
        end else if (n_version != i_cfg.version_code) begin
            status = STAT_BAD_VERSION;
        end else if (n_type == i_cfg.command_type_code) begin
            status = STAT_COMMAND;
        end else if (n_type == i_cfg.data_type_code) begin
            status = STAT_DATA;
        end else begin
            status = STAT_BAD_TYPE;
        end

        n_pos = (r_pos < MaxPos) ? r_pos + PW'(1) : r_pos;
    end

    // Result items for this input item
    always_comb begin
        o_push.pay_valid            = i_accept && pay_ok;
        o_push.stat_valid           = i_accept && i_frame_end;
        o_push.pay.item_kind        = KIND_PAYLOAD;
        o_push.pay.payload_byte     = r_held0;
        o_push.pay.payload_index    = idx_full[9:0];
        o_push.pay.frame_status     = STAT_DATA;
        o_push.pay.declared_length  = n_length;
        o_push.pay.frame_done       = 1'b0;
        o_push.stat.item_kind       = KIND_STATUS;
        o_push.stat.payload_byte    = 8'd0;
        o_push.stat.payload_index   = 10'd0;
        o_push.stat.frame_status    = status;
        o_push.stat.declared_length = stat_len;
        o_push.stat.frame_done      = 1'b1;
    end

    // Advance frame state on each accepted item; clear at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_frame_end)) begin
            r_pos      <= '0;
            r_crc      <= CRC_INIT;
            r_held0    <= 8'd0;
            r_held1    <= 8'd0;
            r_marker   <= 8'd0;
            r_version  <= 8'd0;
            r_type     <= 8'd0;
            r_length   <= 16'd0;
            r_overlong <= 1'b0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_held0    <= n_held0;
            r_held1    <= n_held1;
            r_marker   <= n_marker;
            r_version  <= n_version;
            r_type     <= n_type;
            r_length   <= n_length;
            r_overlong <= n_overlong;
        end
    end

endmodule

// ===== design/crcfc_out_fifo.sv =====
// Four-entry result queue: up to two in per cycle, one out while i_ready.
// Depends on crcfc_pkg.
module crcfc_out_fifo
    import crcfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_item
);

    t_result    r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;
    logic       pop;
    logic [1:0] npush;

    // Room for a full pair from the parser
    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        pop     = o_valid && i_ready;
        npush   = {1'b0, i_push.pay_valid} + {1'b0, i_push.stat_valid};
        n_wr    = r_wr + npush;
        n_rd    = r_rd + {1'b0, pop};
        n_count = r_count + {1'b0, npush} - {2'b00, pop};
    end

    // Store payload first, then status
    always_ff @(posedge i_clk) begin
        if (i_push.pay_valid) begin
            r_mem[r_wr] <= i_push.pay;
        end
        if (i_push.stat_valid) begin
            r_mem[i_push.pay_valid ? r_wr + 2'd1 : r_wr] <= i_push.stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/crc16_frame_checker.sv =====
// Top level of the CRC-16 frame checker: configuration registers, parser, result queue.
// Depends on crcfc_pkg, crcfc_parser and crcfc_out_fifo.
//
//  channel   | direction | tdata                          | tuser     | tlast
//  ----------+-----------+--------------------------------+-----------+-----------
//  s_axis    | in        | rx_byte                        | -         | frame_end
//  m_axis    | out       | payload_byte, index, status,   | item_kind | frame_done
//            |           | declared_length                |           |
//  i_cfg_*   | in        | register index and write data  | -         | -
//
// One byte is taken per cycle while the result queue has room; the byte-wide CRC
// update and header checks are combinational between parser state and result queue.
// A frame's last byte can yield two items, which drain one per cycle on m_axis_tready.
// Input ready drops only while the four-entry result queue holds three or more items.
// Reset is synchronous; frame state returns to its start value after every last byte.
module crc16_frame_checker
    import crcfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [17:8] payload_index,
                                        // [20:18] frame_status, [36:21] declared_length
    output logic        m_axis_tuser,   // [0] item_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);

    t_cfg    r_cfg;
    t_push   push;
    t_result item;
    logic    room;
    logic    accept;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marker_byte       <= 8'hAA;
            r_cfg.version_code      <= 8'h01;
            r_cfg.command_type_code <= 8'h00;
            r_cfg.data_type_code    <= 8'h01;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MARKER:  r_cfg.marker_byte       <= i_cfg_wdata;
                REG_VERSION: r_cfg.version_code      <= i_cfg_wdata;
                REG_CMD:     r_cfg.command_type_code <= i_cfg_wdata;
                REG_DATA:    r_cfg.data_type_code    <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    crcfc_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_rx_byte   (s_axis_tdata),
        .i_frame_end (s_axis_tlast),
        .o_push      (push)
    );

    crcfc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_item  (item)
    );

    // Pack the result item onto the stream
    assign m_axis_tdata = {3'b000, item.declared_length, item.frame_status,
                           item.payload_index, item.payload_byte};
    assign m_axis_tuser = item.item_kind;
    assign m_axis_tlast = item.frame_done;

endmodule

// ===== sim/tb_crc16_frame_checker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for crc16_frame_checker: sends frames one byte per item and
// predicts every payload and status item in the bench. Depends on crcfc_pkg and the RTL.
module tb_crc16_frame_checker;
    import crcfc_pkg::*;

    localparam int FRAME_LIMIT   = 1024;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 262;
    localparam int MAX_REPORTS   = 30;
    localparam int DIR_ROWS      = 23;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Where a directed byte comes from: the table itself or the CRC of the frame so far
    typedef enum logic [1:0] {
        SRC_BYTE,
        SRC_CRC_LO,
        SRC_CRC_HI
    } t_byte_src;

    typedef struct packed {
        t_byte_src   src;
        logic [7:0]  val;
        logic        last;
        logic        typed;
        logic [2:0]  status;
        logic [15:0] length;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;    // [7:0] rx_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;             // [7:0] payload_byte, [17:8] payload_index,
                                           // [20:18] frame_status, [36:21] declared_length
    logic        m_axis_tuser;             // [0] item_kind
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = REG_MARKER;
    logic [7:0]  i_cfg_wdata   = 8'h00;

    // Register copies and frame state of the bench's own checker model
    logic [7:0]  cfg_marker  = 8'hAA;
    logic [7:0]  cfg_version = 8'h01;
    logic [7:0]  cfg_cmd     = 8'h00;
    logic [7:0]  cfg_data    = 8'h01;
    int          rx_count    = 0;
    logic [15:0] run_crc     = 16'hFFFF;
    logic [7:0]  hold_q [2]  = '{8'h00, 8'h00};
    logic [7:0]  hdr_marker  = 8'h00;
    logic [7:0]  hdr_version = 8'h00;
    logic [7:0]  hdr_type    = 8'h00;
    logic [15:0] hdr_length  = 16'h0000;
    logic        too_long    = 1'b0;

    t_result     pending_results [$];
    logic [7:0]  frame_q [$];
    int          sent_items = 0;
    int          errors     = 0;
    int          idle_pct   = 0;
    int          stall_pct  = 0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // one-byte frame
        '{SRC_BYTE,   8'hFF, 1'b1, 1'b1, STAT_LEN_ERR, 16'd0},
        // six bytes: still too short
        '{SRC_BYTE,   8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h00, 1'b1, 1'b1, STAT_LEN_ERR, 16'd0},
        // seven-byte command frame: the CRC low byte doubles as the length high byte
        '{SRC_BYTE,   8'hAA, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h01, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h05, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_CRC_HI, 8'h00, 1'b1, 1'b0, STAT_DATA,    16'd0},
        // data frame with a one-byte payload
        '{SRC_BYTE,   8'hAA, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h01, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h01, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'hFF, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h01, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_BYTE,   8'h5A, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, STAT_DATA,    16'd0},
        '{SRC_CRC_HI, 8'h00, 1'b1, 1'b1, STAT_DATA,    16'd1}
    };

    crc16_frame_checker #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // CRC-16/MODBUS, one input bit at a time, LSB first
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ d[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ 16'hA001;
            end
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    // Advance the checker model by one accepted byte and queue the items it yields
    task automatic predict_frame_byte(input logic [7:0] b, input logic last);
        int         n;
        logic [7:0] rel;
        t_result    r;
        n = rx_count;
        if (n >= FRAME_LIMIT) begin
            too_long = 1'b1;
        end
        case (n)
            0:       hdr_marker = b;
            1:       hdr_version = b;
            2:       hdr_type = b;
            4:       hdr_length[7:0] = b;
            5:       hdr_length[15:8] = b;
            default: ;
        endcase
        // release the older held byte: into the CRC, and out if it is declared payload
        if (n >= 2) begin
            rel     = hold_q[0];
            run_crc = modbus_crc_byte(run_crc, rel);
            if (!too_long && n >= 8 && (n - 8) < int'(hdr_length)) begin
                r                 = '0;
                r.item_kind       = KIND_PAYLOAD;
                r.payload_byte    = rel;
                r.payload_index   = 10'(n - 8);
                r.declared_length = hdr_length;
                pending_results.push_back(r);
            end
        end
        hold_q[0] = hold_q[1];
        hold_q[1] = b;
        if (last) begin
            r                 = '0;
            r.item_kind       = KIND_STATUS;
            r.frame_done      = 1'b1;
            r.declared_length = hdr_length;
            if (n + 1 <= 6 || too_long) begin
                r.frame_status    = STAT_LEN_ERR;
                r.declared_length = '0;
            end else if (run_crc != {hold_q[1], hold_q[0]}) begin
                r.frame_status    = STAT_CRC_ERR;
                r.declared_length = '0;
            end else if (hdr_marker != cfg_marker) begin
                r.frame_status = STAT_BAD_MARKER;
            end else if (hdr_version != cfg_version) begin
                r.frame_status = STAT_BAD_VERSION;
            end else if (hdr_type == cfg_cmd) begin
                r.frame_status = STAT_COMMAND;
            end else if (hdr_type == cfg_data) begin
                r.frame_status = STAT_DATA;
            end else begin
                r.frame_status = STAT_BAD_TYPE;
            end
            pending_results.push_back(r);
            // start the next frame from scratch
            rx_count    = 0;
            run_crc     = 16'hFFFF;
            hold_q[0]   = 8'h00;
            hold_q[1]   = 8'h00;
            hdr_marker  = 8'h00;
            hdr_version = 8'h00;
            hdr_type    = 8'h00;
            hdr_length  = 16'h0000;
            too_long    = 1'b0;
        end else if (rx_count < FRAME_LIMIT) begin
            rx_count++;
        end
    endtask

    // Offer one byte, with random idle cycles ahead of it, and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame_byte(b, last);
        sent_items++;
    endtask

    // Drop valid, wait for every queued item or DRAIN_LIMIT, then let the block settle
    task automatic drain(input int settle);
        int waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_MARKER:  cfg_marker = val;
            REG_VERSION: cfg_version = val;
            REG_CMD:     cfg_cmd = val;
            REG_DATA:    cfg_data = val;
            default:     ;
        endcase
    endtask

    task automatic load_regs(input logic [7:0] m, input logic [7:0] v,
                             input logic [7:0] c, input logic [7:0] d);
        drain(SETTLE_CYCLES);
        write_reg(REG_MARKER, m);
        write_reg(REG_VERSION, v);
        write_reg(REG_CMD, c);
        write_reg(REG_DATA, d);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Build one frame into frame_q; fixed_len >= 0 gives that payload size, true length and CRC
    task automatic build_frame(input int fixed_len);
        int          pick;
        int          plen;
        logic        add_crc;
        logic [15:0] dlen;
        logic [15:0] c;
        frame_q.delete();
        add_crc = 1'b1;
        pick    = (fixed_len >= 0) ? 99 : int'($urandom_range(99));
        if (pick < 8) begin
            // line noise
            add_crc = 1'b0;
            plen    = $urandom_range(1, 40);
            repeat (plen) frame_q.push_back(8'($urandom_range(255)));
        end else if (pick < 18) begin
            // frames below, at or just past the minimum size
            plen    = $urandom_range(1, 8);
            add_crc = (plen >= 3) && ($urandom_range(1) == 1);
            repeat (add_crc ? plen - 2 : plen) frame_q.push_back(8'($urandom_range(255)));
        end else begin
            frame_q.push_back(($urandom_range(99) < 92) ? cfg_marker : 8'($urandom_range(255)));
            frame_q.push_back(($urandom_range(99) < 92) ? cfg_version : 8'($urandom_range(255)));
            case ($urandom_range(9))
                0, 1, 2, 3: frame_q.push_back(cfg_cmd);
                4, 5, 6, 7: frame_q.push_back(cfg_data);
                default:    frame_q.push_back(8'($urandom_range(255)));
            endcase
            frame_q.push_back(8'($urandom_range(255)));
            pick = $urandom_range(99);
            if (fixed_len >= 0) begin
                plen = fixed_len;
            end else if (pick < 85) begin
                plen = $urandom_range(0, 12);
            end else if (pick < 97) begin
                plen = $urandom_range(13, 64);
            end else begin
                plen = $urandom_range(65, 200);
            end
            // declared length mostly matches; sometimes it is short, long or wild
            pick = (fixed_len >= 0) ? 0 : int'($urandom_range(99));
            if (pick < 75) begin
                dlen = 16'(plen);
            end else if (pick < 85) begin
                dlen = 16'($urandom_range(0, plen + 5));
            end else if (pick < 95) begin
                dlen = 16'($urandom_range(65535));
            end else begin
                dlen = 16'hFFFF;
            end
            frame_q.push_back(dlen[7:0]);
            frame_q.push_back(dlen[15:8]);
            repeat (plen) frame_q.push_back(8'($urandom_range(255)));
        end
        if (add_crc) begin
            c = 16'hFFFF;
            foreach (frame_q[i]) begin
                c = modbus_crc_byte(c, frame_q[i]);
            end
            if (fixed_len < 0 && $urandom_range(99) < 6) begin
                c = c ^ 16'(1 << $urandom_range(15));
            end
            frame_q.push_back(c[7:0]);
            frame_q.push_back(c[15:8]);
        end
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) begin
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    // Receiver side: stall at random, at the rate of the current phase
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare every delivered item with the oldest prediction
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.item_kind       = m_axis_tuser;
            seen.payload_byte    = m_axis_tdata[7:0];
            seen.payload_index   = m_axis_tdata[17:8];
            seen.frame_status    = m_axis_tdata[20:18];
            seen.declared_length = m_axis_tdata[36:21];
            seen.frame_done      = m_axis_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch("item with nothing pending", m_axis_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (seen.item_kind != want.item_kind)
                    report_mismatch("item_kind", seen.item_kind, want.item_kind);
                if (seen.payload_byte != want.payload_byte)
                    report_mismatch("payload_byte", seen.payload_byte, want.payload_byte);
                if (seen.payload_index != want.payload_index)
                    report_mismatch("payload_index", seen.payload_index, want.payload_index);
                if (seen.frame_status != want.frame_status)
                    report_mismatch("frame_status", seen.frame_status, want.frame_status);
                if (seen.declared_length != want.declared_length)
                    report_mismatch("declared_length", seen.declared_length,
                                    want.declared_length);
                if (seen.frame_done != want.frame_done)
                    report_mismatch("frame_done", seen.frame_done, want.frame_done);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_crc16_frame_checker NOT OK");
        $finish;
    end

    initial begin
        logic [15:0] tx_crc;
        logic [7:0]  b;
        int          p;
        int          start;
        tx_crc = 16'hFFFF;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at the reset register values
        foreach (dir_rows[i]) begin
            case (dir_rows[i].src)
                SRC_CRC_LO: b = tx_crc[7:0];
                SRC_CRC_HI: b = tx_crc[15:8];
                default: begin
                    b      = dir_rows[i].val;
                    tx_crc = modbus_crc_byte(tx_crc, b);
                end
            endcase
            send_byte(b, dir_rows[i].last);
            if (dir_rows[i].typed) begin
                pending_results[$].frame_status    = dir_rows[i].status;
                pending_results[$].declared_length = dir_rows[i].length;
            end
            if (dir_rows[i].last) begin
                tx_crc = 16'hFFFF;
            end
        end

        // random frames under several register settings and idling patterns
        for (p = 0; p < 4; p++) begin
            case (p)
                1: load_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
                2: load_regs(8'hFF, 8'h00, 8'h5A, 8'h5A);
                3: load_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
                default: ;
            endcase
            idle_pct  = (p == 1) ? 60 : (p == 3) ? 31 : 0;
            stall_pct = (p == 2) ? 60 : (p == 3) ? 31 : 0;
            start     = sent_items;
            while (sent_items - start < PHASE_ITEMS) begin
                build_frame(-1);
                send_frame();
                // now and then hold the sender until the output side is empty
                if ($urandom_range(99) < 3) begin
                    drain(0);
                end
            end
        end

        drain(SETTLE_CYCLES);
        if (pending_results.size() != 0) begin
            report_mismatch("items never delivered", pending_results.size(), 0);
        end
        if (errors == 0) begin
            $display("tb_crc16_frame_checker OK");
        end else begin
            $display("tb_crc16_frame_checker NOT OK");
        end
        $finish;
    end

endmodule
